@@ rtl/sdks_pkg.sv @@
// shared types and constants for the scancode decoder key stack
// no dependencies

package sdks_pkg;

    localparam int STACK_DEPTH = 256;
    localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = 3;

    localparam logic [7:0]  PREFIX_EXT    = 8'hE0;
    localparam logic [7:0]  PREFIX_PAUSE  = 8'hE1;
    localparam logic [15:0] EXT_BASE      = 16'h0100;
    localparam logic [15:0] CODE_PAUSE    = 16'h1D45;
    localparam logic [15:0] CODE_SPACE    = 16'h0039;

    localparam logic REG_CAPTURE = 1'b0;
    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_POP    = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] scancode_byte;
    } sc_item_t;

    typedef struct packed {
        logic [7:0]  popped_key;
        logic        code_valid;
        logic [15:0] key_code;
        logic        key_pressed;
        logic        debug_request;
        logic        stack_dropped;
    } res_item_t;

    typedef struct packed {
        logic push;
        logic pop;
    } shift_t;

    typedef struct packed {
        logic       push_req;
        logic       pop_req;
        logic [7:0] push_byte;
    } stack_ctrl_t;

    typedef struct packed {
        logic       empty;
        logic       full;
        logic [7:0] top;
    } stack_stat_t;

    typedef struct packed {
        logic        code_valid;
        logic [15:0] key_code;
        logic        debug_request;
    } dec_t;

endpackage

@@ rtl/sdks_cell.sv @@
// one stack cell: holds a byte, loads from the cell above on push, below on pop
// depends on sdks_pkg

module sdks_cell
    import sdks_pkg::*;
(
    input  logic       clk,
    input  shift_t     shift,
    input  logic [7:0] above,
    input  logic [7:0] below,
    output logic [7:0] q
);

    logic [7:0] data_reg;

    always_ff @(posedge clk)
    begin
        if (shift.push)
        begin
            data_reg <= above;
        end
        else if (shift.pop)
        begin
            data_reg <= below;
        end
    end

    assign q = data_reg;

endmodule

@@ rtl/sdks_stack.sv @@
// lifo key stack built as a chain of shifting cells, top in cell 0
// depends on sdks_pkg, sdks_cell

module sdks_stack
    import sdks_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  stack_ctrl_t ctrl,
    output stack_stat_t stat
);

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [7:0]         cell_q [STACK_DEPTH];
    shift_t             shift;
    logic               empty;
    logic               full;

    assign empty      = (count_reg == '0);
    assign full       = (count_reg == COUNT_W'(STACK_DEPTH));
    assign shift.push = ctrl.push_req && !full;
    assign shift.pop  = ctrl.pop_req && !empty;

    always_comb
    begin
        count_next = count_reg;
        if (shift.push)
        begin
            count_next = count_reg + COUNT_W'(1);
        end
        else if (shift.pop)
        begin
            count_next = count_reg - COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    for (genvar i = 0; i < STACK_DEPTH; i++)
    begin : g_cell
        logic [7:0] above;
        logic [7:0] below;

        if (i == 0)
        begin : g_first
            assign above = ctrl.push_byte;
        end
        else
        begin : g_mid_a
            assign above = cell_q[i-1];
        end

        if (i == STACK_DEPTH - 1)
        begin : g_last
            assign below = '0;
        end
        else
        begin : g_mid_b
            assign below = cell_q[i+1];
        end

        sdks_cell u_cell (
            .clk   (clk),
            .shift (shift),
            .above (above),
            .below (below),
            .q     (cell_q[i])
        );
    end

    assign stat.empty = empty;
    assign stat.full  = full;
    assign stat.top   = cell_q[0];

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(STACK_DEPTH))
        else $error("stack count above depth");

    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.pop_req && !ctrl.push_req && empty) |=> (count_reg == '0))
        else $error("pop on empty stack changed count");

    a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.push_req && !ctrl.pop_req && full) |=> $stable(count_reg))
        else $error("push on full stack changed count");

endmodule

@@ rtl/sdks_prefix.sv @@
// set-1 prefix tracker: e0 extended codes and e1 two-byte codes
// depends on sdks_pkg

module sdks_prefix
    import sdks_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] scancode_byte,
    output dec_t       dec
);

    typedef enum logic [1:0] {
        PFX_NONE  = 2'd0,
        PFX_LAST  = 2'd1,
        PFX_FIRST = 2'd2
    } pfx_state_t;

    pfx_state_t  state_reg;
    pfx_state_t  state_next;
    logic [15:0] saved_reg;
    logic [15:0] saved_next;
    logic [15:0] low7;
    logic        pressed;

    assign low7    = {9'b0, scancode_byte[6:0]};
    assign pressed = !scancode_byte[7];

    always_comb
    begin
        state_next     = state_reg;
        saved_next     = saved_reg;
        dec.code_valid = 1'b0;
        dec.key_code   = '0;
        case (state_reg)
            PFX_NONE:
            begin
                if (scancode_byte == PREFIX_EXT)
                begin
                    state_next = PFX_LAST;
                    saved_next = EXT_BASE;
                end
                else if (scancode_byte == PREFIX_PAUSE)
                begin
                    state_next = PFX_FIRST;
                    saved_next = '0;
                end
                else
                begin
                    dec.code_valid = 1'b1;
                    dec.key_code   = low7;
                end
            end
            PFX_LAST:
            begin
                state_next     = PFX_NONE;
                dec.code_valid = 1'b1;
                dec.key_code   = low7 | saved_reg;
            end
            default:
            begin
                state_next = PFX_LAST;
                saved_next = saved_reg | {1'b0, scancode_byte[6:0], 8'h00};
            end
        endcase
        dec.debug_request = dec.code_valid && pressed &&
                            (dec.key_code == CODE_PAUSE || dec.key_code == CODE_SPACE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PFX_NONE;
            saved_reg <= '0;
        end
        else if (step)
        begin
            state_reg <= state_next;
            saved_reg <= saved_next;
        end
    end

endmodule

@@ rtl/scancode_decoder_key_stack_unit.sv @@
// scancode decoder key stack: top level with apb register, handshake and result register
// depends on sdks_pkg, sdks_stack, sdks_prefix
//
// usage:
//   sc channel (sc_valid, sc_stall, sc_data) carries one transaction per scancode
//   byte (kind 0) or pop request (kind 1). res channel (res_valid, res_stall,
//   res_data) returns exactly one result transaction for each.
//   a transaction's result is registered and shows on res the following cycle.
//   one transaction per cycle is sustained while res_stall is low.
//   while a result waits under res_stall, sc_stall is raised; as soon as the
//   waiting result is taken a new transaction is accepted in the same cycle.
//   apb register 0 (address 0) bit 0 is capture_enable; write it only while idle.
//   reset clears the stack count, prefix state, capture_enable and the result
//   valid flag; stack cell contents are left as they are and are never read
//   before being written.

module scancode_decoder_key_stack_unit
    import sdks_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              sc_valid,
    output logic              sc_stall,
    input  sc_item_t          sc_data,
    output logic              res_valid,
    input  logic              res_stall,
    output res_item_t         res_data
);

    logic        capture_reg;
    logic        res_valid_reg;
    res_item_t   res_reg;
    res_item_t   res_next;
    logic        accept;
    logic        is_byte;
    logic        pressed;
    stack_ctrl_t stack_ctrl;
    stack_stat_t stack_stat;
    dec_t        dec;

    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_CAPTURE) ? {31'b0, capture_reg} : '0;
    assign sc_stall = res_valid_reg && res_stall;
    assign accept   = sc_valid && !sc_stall;
    assign is_byte  = (sc_data.kind == KIND_BYTE);
    assign pressed  = !sc_data.scancode_byte[7];

    assign stack_ctrl.push_req  = accept && is_byte && pressed && capture_reg;
    assign stack_ctrl.pop_req   = accept && (sc_data.kind == KIND_POP);
    assign stack_ctrl.push_byte = sc_data.scancode_byte;

    sdks_stack u_stack (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (stack_ctrl),
        .stat  (stack_stat)
    );

    sdks_prefix u_prefix (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (accept && is_byte),
        .scancode_byte (sc_data.scancode_byte),
        .dec           (dec)
    );

    always_comb
    begin
        res_next = '0;
        if (is_byte)
        begin
            res_next.code_valid    = dec.code_valid;
            res_next.key_code      = dec.key_code;
            res_next.key_pressed   = pressed;
            res_next.debug_request = dec.debug_request;
            res_next.stack_dropped = pressed && capture_reg && stack_stat.full;
        end
        else if (!stack_stat.empty)
        begin
            res_next.popped_key = stack_stat.top;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capture_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr[2] == REG_CAPTURE)
            begin
                capture_reg <= pwdata[0];
            end
            if (accept)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

    a_debug_needs_code: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_data.debug_request) |->
            (res_data.code_valid && res_data.key_pressed))
        else $error("debug request without completed pressed code");

    a_drop_needs_press: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_data.stack_dropped) |-> res_data.key_pressed)
        else $error("stack drop on a non-press");

    a_pop_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_data.popped_key != 8'h00) |->
            (!res_data.key_pressed && !res_data.code_valid))
        else $error("pop result carries decode fields");

endmodule

@@ tb/tb.sv @@
// testbench for scancode_decoder_key_stack_unit: directed and random scancode/pop traffic
// with random idling on both channels, checked against a scoreboard that models decode and stack
// depends on sdks_pkg and the scancode_decoder_key_stack_unit rtl

module tb;
    import sdks_pkg::*;

    localparam int IDLE_LIMIT = 2000;

    class key_stack_scoreboard;
        logic [7:0]  stack_mem [STACK_DEPTH];
        int unsigned depth;
        int unsigned prefix_left;
        logic [15:0] prefix_code;
        logic        capture;
        res_item_t   decoded_due [$];
        int unsigned errors;

        function new();
            depth       = 0;
            prefix_left = 0;
            prefix_code = '0;
            capture     = 1'b0;
            errors      = 0;
        endfunction

        function void decode_transaction(sc_item_t t);
            res_item_t  r;
            logic [7:0] b;
            r = '0;
            b = t.scancode_byte;
            if (t.kind == KIND_POP)
            begin
                if (depth > 0)
                begin
                    depth--;
                    r.popped_key = stack_mem[depth];
                end
            end
            else
            begin
                r.key_pressed = ~b[7];
                if (r.key_pressed && capture)
                begin
                    if (depth < STACK_DEPTH)
                    begin
                        stack_mem[depth] = b;
                        depth++;
                    end
                    else
                        r.stack_dropped = 1'b1;
                end
                if (prefix_left == 0)
                begin
                    if (b == PREFIX_EXT)
                    begin
                        prefix_left = 1;
                        prefix_code = EXT_BASE;
                    end
                    else if (b == PREFIX_PAUSE)
                    begin
                        prefix_left = 2;
                        prefix_code = '0;
                    end
                    else
                    begin
                        r.code_valid = 1'b1;
                        r.key_code   = {9'd0, b[6:0]};
                    end
                end
                else if (prefix_left == 1)
                begin
                    prefix_left  = 0;
                    r.code_valid = 1'b1;
                    r.key_code   = prefix_code | {9'd0, b[6:0]};
                end
                else
                begin
                    prefix_left = 1;
                    prefix_code = prefix_code | {1'b0, b[6:0], 8'd0};
                end
                r.debug_request = r.code_valid && r.key_pressed &&
                                  (r.key_code == CODE_PAUSE || r.key_code == CODE_SPACE);
            end
            decoded_due.push_back(r);
        endfunction

        function void field_diff(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            end
        endfunction

        function void check_result(res_item_t got);
            res_item_t want;
            if (decoded_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                return;
            end
            want = decoded_due.pop_front();
            field_diff("popped_key", want.popped_key, got.popped_key);
            field_diff("code_valid", want.code_valid, got.code_valid);
            field_diff("key_code", want.key_code, got.key_code);
            field_diff("key_pressed", want.key_pressed, got.key_pressed);
            field_diff("debug_request", want.debug_request, got.debug_request);
            field_diff("stack_dropped", want.stack_dropped, got.stack_dropped);
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              sc_valid;
    logic              sc_stall;
    sc_item_t          sc_data;
    logic              res_valid;
    logic              res_stall;
    res_item_t         res_data;

    key_stack_scoreboard sb;
    bit                  tx_idle;
    bit                  rx_idle;
    int unsigned         sent;
    int unsigned         stall_left;
    int unsigned         quiet;

    scancode_decoder_key_stack_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .sc_valid  (sc_valid),
        .sc_stall  (sc_stall),
        .sc_data   (sc_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    task automatic write_capture(logic value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({REG_CAPTURE, 2'b00});
        pwdata  <= {31'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.capture = value;
    endtask

    task automatic send_item(logic kind, logic [7:0] b);
        int unsigned gap;
        gap = tx_idle ? $urandom_range(0, 12) : 0;
        if (gap > 0)
        begin
            sc_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sc_valid <= 1'b1;
        sc_data  <= sc_item_t'{kind: kind, scancode_byte: b};
        do
            @(posedge clk);
        while (sc_stall !== 1'b0);
        sb.decode_transaction(sc_data);
        sent++;
    endtask

    task automatic wait_drained();
        sc_valid <= 1'b0;
        while (sb.decoded_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_sequence(int unsigned pop_pct, bit press_only);
        logic rel;
        logic [7:0] mid;
        rel = 1'($urandom);
        mid = $urandom_range(0, 1) ? PREFIX_EXT : PREFIX_PAUSE;
        if (press_only)
            send_item(KIND_BYTE, {1'b0, 7'($urandom)});
        else if ($urandom_range(0, 99) < pop_pct)
            send_item(KIND_POP, 8'($urandom));
        else
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                    send_item(KIND_BYTE, 8'($urandom));
                4:
                begin
                    send_item(KIND_BYTE, PREFIX_EXT);
                    send_item(KIND_BYTE, 8'($urandom));
                end
                5:
                begin
                    send_item(KIND_BYTE, PREFIX_PAUSE);
                    send_item(KIND_BYTE, 8'($urandom));
                    send_item(KIND_BYTE, 8'($urandom));
                end
                6:
                begin
                    send_item(KIND_BYTE, PREFIX_PAUSE);
                    send_item(KIND_BYTE, {rel, CODE_PAUSE[14:8]});
                    send_item(KIND_BYTE, {rel, CODE_PAUSE[6:0]});
                end
                7:
                    send_item(KIND_BYTE, {rel, CODE_SPACE[6:0]});
                8:
                begin
                    // prefix bytes landing inside a pending prefix
                    send_item(KIND_BYTE, PREFIX_PAUSE);
                    send_item(KIND_BYTE, mid);
                    send_item(KIND_BYTE, $urandom_range(0, 1) ? mid : 8'($urandom));
                end
                default:
                    repeat (3)
                        send_item(KIND_BYTE, $urandom_range(0, 2) == 0 ? mid : 8'($urandom));
            endcase
    endtask

    task automatic run_random(int unsigned count, int unsigned pop_pct, bit press_only);
        int unsigned start;
        start = sent;
        while (sent - start < count)
        begin
            if ($urandom_range(0, 39) == 0)
            begin
                tx_idle = $urandom_range(0, 2) != 0;
                rx_idle = $urandom_range(0, 2) != 0;
            end
            send_sequence(pop_pct, press_only);
        end
    endtask

    // result side: random stall after each accepted result
    always @(posedge clk)
    begin
        if (res_valid === 1'b1 && res_stall == 1'b0)
        begin
            sb.check_result(res_data);
            stall_left = rx_idle ? $urandom_range(0, 12) : 0;
        end
        else if (stall_left > 0)
            stall_left--;
        res_stall <= (stall_left > 0);
    end

    always @(posedge clk)
    begin
        if ((sc_valid && sc_stall === 1'b0) || (res_valid === 1'b1 && !res_stall) ||
            (psel && penable))
            quiet = 0;
        else
        begin
            quiet++;
            if (quiet >= IDLE_LIMIT)
            begin
                $display("tb NOT OK");
                $finish;
            end
        end
    end

    initial
    begin
        sb         = new();
        sent       = 0;
        stall_left = 0;
        quiet      = 0;
        tx_idle    = 1'b1;
        rx_idle    = 1'b1;
        rst_n     <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        sc_valid  <= 1'b0;
        sc_data   <= '0;
        res_stall <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // capture off after reset: empty pop, press not stored
        send_item(KIND_POP, 8'hFF);
        send_item(KIND_BYTE, 8'h00);
        wait_drained();
        write_capture(1'b1);

        send_item(KIND_BYTE, 8'h00);
        send_item(KIND_BYTE, 8'h7F);
        send_item(KIND_BYTE, 8'h80);
        send_item(KIND_BYTE, 8'hFF);
        send_item(KIND_BYTE, {1'b0, CODE_SPACE[6:0]});
        send_item(KIND_BYTE, {1'b1, CODE_SPACE[6:0]});
        send_item(KIND_BYTE, PREFIX_EXT);
        send_item(KIND_BYTE, 8'h48);
        send_item(KIND_BYTE, PREFIX_EXT);
        send_item(KIND_BYTE, PREFIX_PAUSE);
        send_item(KIND_BYTE, PREFIX_PAUSE);
        send_item(KIND_BYTE, {1'b0, CODE_PAUSE[14:8]});
        send_item(KIND_POP, 8'h00);
        send_item(KIND_BYTE, {1'b0, CODE_PAUSE[6:0]});
        send_item(KIND_BYTE, PREFIX_PAUSE);
        send_item(KIND_BYTE, {1'b1, CODE_PAUSE[14:8]});
        send_item(KIND_BYTE, {1'b1, CODE_PAUSE[6:0]});
        send_item(KIND_BYTE, PREFIX_PAUSE);
        send_item(KIND_BYTE, PREFIX_EXT);
        send_item(KIND_BYTE, PREFIX_PAUSE);
        repeat (3) send_item(KIND_POP, 8'($urandom));

        run_random(250, 25, 1'b0);
        // presses only, enough to fill the stack and hit drops
        run_random(300, 0, 1'b1);
        wait_drained();
        write_capture(1'b0);
        run_random(400, 75, 1'b0);
        wait_drained();
        write_capture(1'b1);
        run_random(200, 30, 1'b0);
        wait_drained();
        repeat (8) @(posedge clk);

        if (sb.errors == 0 && sb.decoded_due.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

@@ files.f @@
rtl/sdks_pkg.sv
rtl/sdks_cell.sv
rtl/sdks_stack.sv
rtl/sdks_prefix.sv
rtl/scancode_decoder_key_stack_unit.sv
tb/tb.sv
